### src/masked_byte_pattern_scanner_core_defines.svh
// assertion macros shared by the scanner modules
// no dependencies; included by the files that carry assertions
`ifndef MASKED_BYTE_PATTERN_SCANNER_CORE_DEFINES_SVH
`define MASKED_BYTE_PATTERN_SCANNER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MBPS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define MBPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/mbps_pkg.sv
// shared types and constants of the masked byte pattern scanner
// no dependencies; used by the interfaces and every module
`timescale 1ns / 1ps

package mbps_pkg;

   localparam int ADDR_WIDTH        = 64;
   localparam int BYTE_WIDTH        = 8;
   localparam int WORD_WIDTH        = 32;
   localparam int PATTERN_WIDTH     = 64;
   localparam int MASK_WIDTH        = 16;
   localparam int LEN_WIDTH         = 5;
   localparam int PAT_INDEX_WIDTH   = 4;
   localparam int CSR_INDEX_WIDTH   = 3;
   localparam int CSR_DATA_WIDTH    = 64;
   localparam int MAX_PATTERN_BYTES = 16;
   localparam int QUEUE_DEPTH       = 4;
   localparam int VALUE_SPAN        = 3;
   localparam int PATTERN_LENGTH_RESET = 4;

   typedef enum logic [1:0] {
      MODE_VALUE    = 2'd0,
      MODE_FLOAT    = 2'd1,
      MODE_STRING   = 2'd2,
      MODE_WILDCARD = 2'd3
   } scan_mode_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_SCAN_MODE      = 3'd0,
      REG_TARGET_WORD    = 3'd1,
      REG_PATTERN_LOW    = 3'd2,
      REG_PATTERN_HIGH   = 3'd3,
      REG_WILDCARD_MASK  = 3'd4,
      REG_PATTERN_LENGTH = 3'd5
   } reg_index_type;

   typedef struct packed {
      scan_mode_type                scan_mode;
      logic [WORD_WIDTH-1:0]        target_word;
      logic [PATTERN_WIDTH-1:0]     pattern_low;
      logic [PATTERN_WIDTH-1:0]     pattern_high;
      logic [MASK_WIDTH-1:0]        wildcard_mask;
      logic [LEN_WIDTH-1:0]         pattern_length;
   } cfg_type;

   // hit_a: string match closed by a zero byte (earlier start)
   // hit_b: any other match, reported after hit_a
   typedef struct packed {
      logic                  hit_a;
      logic                  hit_b;
      logic [ADDR_WIDTH-1:0] addr_a;
      logic [ADDR_WIDTH-1:0] addr_b;
   } match_entry_type;

endpackage

### src/mbps_if.sv
// valid/ready channel interfaces of the scanner: byte input, match output, csr writes
// depends on mbps_pkg for field widths
`timescale 1ns / 1ps

interface mbps_req_if;
   logic                                valid;
   logic                                ready;
   logic [mbps_pkg::BYTE_WIDTH-1:0]     data_byte;
   logic [mbps_pkg::ADDR_WIDTH-1:0]     byte_address;
   logic                                region_end;

   modport source (output valid, data_byte, byte_address, region_end, input ready);
   modport sink   (input valid, data_byte, byte_address, region_end, output ready);
endinterface

interface mbps_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [mbps_pkg::ADDR_WIDTH-1:0]     match_address;
   logic                                last_result;

   modport source (output valid, match_address, last_result, input ready);
   modport sink   (input valid, match_address, last_result, output ready);
endinterface

interface mbps_csr_if;
   logic                                   valid;
   logic                                   ready;
   logic [mbps_pkg::CSR_INDEX_WIDTH-1:0]   index;
   logic [mbps_pkg::CSR_DATA_WIDTH-1:0]    write_data;

   modport source (output valid, index, write_data, input ready);
   modport sink   (input valid, index, write_data, output ready);
endinterface

### src/mbps_front.sv
// front end: takes one byte a beat, shifts the window and finds the matches ending there
// depends on mbps_pkg and mbps_req_if; feeds match entries into mbps_queue
`timescale 1ns / 1ps

module mbps_front #(
   parameter int MAX_PATTERN_BYTES = mbps_pkg::MAX_PATTERN_BYTES
) (
   input  logic                      clock,
   input  logic                      reset,
   input  mbps_pkg::cfg_type         cfg,
   mbps_req_if.sink                  req_bus,
   input  logic                      q_full,
   output logic                      push_valid,
   output mbps_pkg::match_entry_type push_entry
);

   localparam int LW  = mbps_pkg::LEN_WIDTH;
   localparam int BW  = mbps_pkg::BYTE_WIDTH;
   localparam int PIW = mbps_pkg::PAT_INDEX_WIDTH;
   localparam int AW  = mbps_pkg::ADDR_WIDTH;
   localparam int WIN_DEPTH = MAX_PATTERN_BYTES + 1;
   localparam int HW  = $clog2(WIN_DEPTH + 1);
   localparam int CW  = LW + 1;

   function automatic logic float_equal(input logic [31:0] a, input logic [31:0] b);
      logic a_nan;
      logic b_nan;
      a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
      b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
      if (a_nan || b_nan) begin
         return 1'b0;
      end
      if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
         return 1'b1;
      end
      return a == b;
   endfunction

   logic [BW-1:0] window_ff [MAX_PATTERN_BYTES];
   logic [BW-1:0] window_in [MAX_PATTERN_BYTES];
   logic [HW-1:0] held_ff;
   logic [HW-1:0] held_in;

   logic [BW-1:0]  win [WIN_DEPTH];
   logic [LW-1:0]  len;
   logic [127:0]   pat_all;
   logic [PIW-1:0] pidx [MAX_PATTERN_BYTES];
   logic [BW-1:0]  apat [MAX_PATTERN_BYTES];
   logic           wild_al [MAX_PATTERN_BYTES];
   logic           used [MAX_PATTERN_BYTES];
   logic           cmp_end;
   logic           cmp_prev;
   logic           match_end;
   logic           match_prev;
   logic [31:0]    word;
   logic           word_hit;
   logic           use_wild;
   logic [LW-1:0]  off_b;
   logic           accept;
   logic           hit_a;
   logic           hit_b;

   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = !q_full;
   assign pat_all       = {cfg.pattern_high, cfg.pattern_low};
   assign use_wild      = (cfg.scan_mode == mbps_pkg::MODE_WILDCARD);

   assign len = (cfg.pattern_length > LW'(MAX_PATTERN_BYTES)) ? LW'(MAX_PATTERN_BYTES)
                                                              : cfg.pattern_length;

   // window as seen after this beat's shift, entry 0 newest
   always_comb begin
      win[0] = req_bus.data_byte;
      for (int k = 1; k < WIN_DEPTH; k++) begin
         win[k] = window_ff[k-1];
      end
   end

   assign held_in = (held_ff < HW'(WIN_DEPTH)) ? held_ff + HW'(1) : held_ff;

   // pattern reversed so that aligned byte j lines up with window entry j (or j+1)
   always_comb begin
      for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
         used[j]    = (LW'(j) < len);
         pidx[j]    = PIW'(len - LW'(1) - LW'(j));
         apat[j]    = pat_all[pidx[j]*BW +: BW];
         wild_al[j] = cfg.wildcard_mask[pidx[j]];
      end
   end

   always_comb begin
      cmp_end  = 1'b1;
      cmp_prev = 1'b1;
      for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
         if (used[j] && !(use_wild && wild_al[j]) && (win[j] != apat[j])) begin
            cmp_end = 1'b0;
         end
         if (used[j] && (win[j+1] != apat[j])) begin
            cmp_prev = 1'b0;
         end
      end
   end

   assign match_end  = cmp_end && (len != '0) && (CW'(len) <= CW'(held_in));
   assign match_prev = cmp_prev && (len != '0) && (CW'(len) + CW'(1) <= CW'(held_in));

   assign word     = {win[0], win[1], win[2], win[3]};
   assign word_hit = (held_in >= HW'(4)) &&
                     ((cfg.scan_mode == mbps_pkg::MODE_VALUE) ? (word == cfg.target_word)
                                                              : float_equal(word, cfg.target_word));

   always_comb begin
      hit_a = 1'b0;
      hit_b = 1'b0;
      off_b = len - LW'(1);
      unique case (cfg.scan_mode) inside
         mbps_pkg::MODE_VALUE, mbps_pkg::MODE_FLOAT: begin
            hit_b = word_hit;
            off_b = LW'(mbps_pkg::VALUE_SPAN);
         end
         mbps_pkg::MODE_STRING: begin
            hit_a = (win[0] == '0) && match_prev;
            hit_b = req_bus.region_end && match_end;
         end
         mbps_pkg::MODE_WILDCARD: begin
            hit_b = match_end;
         end
         default: begin
            hit_b = 1'b0;
         end
      endcase
   end

   assign push_valid        = accept && (hit_a || hit_b);
   assign push_entry.hit_a  = hit_a;
   assign push_entry.hit_b  = hit_b;
   assign push_entry.addr_a = req_bus.byte_address - AW'(len);
   assign push_entry.addr_b = req_bus.byte_address - AW'(off_b);

   always_comb begin
      for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
         window_in[k] = win[k];
      end
   end

   // window contents need no reset: held_ff gates every compare
   always_ff @(posedge clock) begin
      if (accept) begin
         window_ff <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else if (accept) begin
         held_ff <= req_bus.region_end ? '0 : held_in;
      end
   end

endmodule

### src/mbps_queue.sv
// short fifo of match entries between the front end and the result stage
// depends on mbps_pkg and the assertion macros header
`timescale 1ns / 1ps
`include "masked_byte_pattern_scanner_core_defines.svh"

module mbps_queue #(
   parameter int DEPTH = mbps_pkg::QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   input  mbps_pkg::match_entry_type push_entry,
   output logic                      full,
   output logic                      head_valid,
   output mbps_pkg::match_entry_type head_entry,
   input  logic                      pop
);

   localparam int PW = $clog2(DEPTH);
   localparam int NW = $clog2(DEPTH + 1);

   mbps_pkg::match_entry_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff;
   logic [PW-1:0] wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff;
   logic [PW-1:0] rd_ptr_in;
   logic [NW-1:0] count_ff;
   logic [NW-1:0] count_in;
   logic          do_push;
   logic          do_pop;

   assign full       = (count_ff == NW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   assign wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
   assign rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + NW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         count_ff <= count_in;
      end
   end

   `MBPS_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= NW'(DEPTH), "queue count over depth")
   `MBPS_ASSERT_NOW(a_pop_nonempty, clock, reset, pop, head_valid, "pop from empty queue")
   `MBPS_ASSERT_NEXT(a_head_holds, clock, reset, head_valid && !pop, $stable(head_entry), "queue head changed")

endmodule

### src/mbps_back.sv
// result stage: turns queued match entries into result beats, one or two per entry
// depends on mbps_pkg, mbps_rsp_if and the assertion macros header
`timescale 1ns / 1ps
`include "masked_byte_pattern_scanner_core_defines.svh"

module mbps_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_valid,
   input  mbps_pkg::match_entry_type q_entry,
   output logic                      q_pop,
   mbps_rsp_if.source                rsp_bus
);

   localparam int AW = mbps_pkg::ADDR_WIDTH;

   logic          out_valid_ff;
   logic          out_valid_in;
   logic [AW-1:0] out_addr_ff;
   logic [AW-1:0] out_addr_in;
   logic          out_last_ff;
   logic          out_last_in;
   logic          pend_valid_ff;
   logic          pend_valid_in;
   logic [AW-1:0] pend_addr_ff;
   logic [AW-1:0] pend_addr_in;
   logic          can_load;

   assign can_load = !out_valid_ff || rsp_bus.ready;
   assign q_pop    = can_load && !pend_valid_ff && q_valid;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_addr_in   = out_addr_ff;
      out_last_in   = out_last_ff;
      pend_valid_in = pend_valid_ff;
      pend_addr_in  = pend_addr_ff;
      if (can_load) begin
         if (pend_valid_ff) begin
            // second result of a two-match beat
            out_valid_in  = 1'b1;
            out_addr_in   = pend_addr_ff;
            out_last_in   = 1'b1;
            pend_valid_in = 1'b0;
         end else if (q_valid) begin
            out_valid_in = 1'b1;
            if (q_entry.hit_a && q_entry.hit_b) begin
               out_addr_in   = q_entry.addr_a;
               out_last_in   = 1'b0;
               pend_valid_in = 1'b1;
               pend_addr_in  = q_entry.addr_b;
            end else begin
               out_addr_in = q_entry.hit_a ? q_entry.addr_a : q_entry.addr_b;
               out_last_in = 1'b1;
            end
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
      out_addr_ff  <= out_addr_in;
      out_last_ff  <= out_last_in;
      pend_addr_ff <= pend_addr_in;
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.match_address = out_addr_ff;
   assign rsp_bus.last_result   = out_last_ff;

   `MBPS_ASSERT_NOW(a_pend_behind_first, clock, reset, pend_valid_ff, out_valid_ff && !out_last_ff, "pending result without first")
   `MBPS_ASSERT_NEXT(a_second_follows, clock, reset, out_valid_ff && rsp_bus.ready && !out_last_ff, out_valid_ff && out_last_ff, "second result missing")
   `MBPS_ASSERT_NOW(a_pop_when_free, clock, reset, q_pop, q_valid && !pend_valid_ff, "entry taken while busy")

endmodule

### src/masked_byte_pattern_scanner_core.sv
// Masked byte pattern scanner: takes one memory byte per beat and reports the start address
// of each match that the byte closes, in value, float, string or wildcard pattern mode.
// A byte is accepted every cycle while the four-entry match queue has room; the window
// compare is fully parallel, so bytes stream in at one byte per cycle until the queue fills. Results
// leave one per cycle while the receiver is ready, from a registered output stage; a byte
// that ends two string matches takes two output beats, which the match queue absorbs.
// Configuration writes are taken every cycle and must only be issued while the block is idle.
`timescale 1ns / 1ps

module masked_byte_pattern_scanner_core #(
   parameter int MAX_PATTERN_BYTES = mbps_pkg::MAX_PATTERN_BYTES,
   parameter int QUEUE_DEPTH       = mbps_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   mbps_req_if.sink   req_bus,
   mbps_rsp_if.source rsp_bus,
   mbps_csr_if.sink   csr_bus
);

   mbps_pkg::cfg_type         cfg_ff;
   mbps_pkg::cfg_type         cfg_in;
   logic                      push_valid;
   mbps_pkg::match_entry_type push_entry;
   logic                      q_full;
   logic                      q_valid;
   mbps_pkg::match_entry_type q_entry;
   logic                      q_pop;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            mbps_pkg::REG_SCAN_MODE: begin
               cfg_in.scan_mode = mbps_pkg::scan_mode_type'(csr_bus.write_data[1:0]);
            end
            mbps_pkg::REG_TARGET_WORD: begin
               cfg_in.target_word = csr_bus.write_data[mbps_pkg::WORD_WIDTH-1:0];
            end
            mbps_pkg::REG_PATTERN_LOW: begin
               cfg_in.pattern_low = csr_bus.write_data;
            end
            mbps_pkg::REG_PATTERN_HIGH: begin
               cfg_in.pattern_high = csr_bus.write_data;
            end
            mbps_pkg::REG_WILDCARD_MASK: begin
               cfg_in.wildcard_mask = csr_bus.write_data[mbps_pkg::MASK_WIDTH-1:0];
            end
            mbps_pkg::REG_PATTERN_LENGTH: begin
               cfg_in.pattern_length = csr_bus.write_data[mbps_pkg::LEN_WIDTH-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scan_mode      <= mbps_pkg::MODE_VALUE;
         cfg_ff.target_word    <= '0;
         cfg_ff.pattern_low    <= '0;
         cfg_ff.pattern_high   <= '0;
         cfg_ff.wildcard_mask  <= '0;
         cfg_ff.pattern_length <= mbps_pkg::LEN_WIDTH'(mbps_pkg::PATTERN_LENGTH_RESET);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mbps_front #(
      .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_bus    (req_bus),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   mbps_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (q_full),
      .head_valid (q_valid),
      .head_entry (q_entry),
      .pop        (q_pop)
   );

   mbps_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_entry (q_entry),
      .q_pop   (q_pop),
      .rsp_bus (rsp_bus)
   );

endmodule
